### sv/first_fit_chunk_bump_allocator_macros.svh
// ----------------------------------------------------------------------------
// First-fit chunk bump allocator assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CHUNK_BUMP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CHUNK_BUMP_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFCBA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFCBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ffcba_pkg.sv
// ----------------------------------------------------------------------------
// First-fit chunk bump allocator package
// Field widths, command and status codes, and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package ffcba_pkg;

    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 36;
    localparam int INDEX_W = 4;

    localparam logic [SIZE_W-1:0] CHUNK_SIZE_RESET = 32'd16777216;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NULL      = 2'd1,
        STATUS_TOO_LARGE = 2'd2,
        STATUS_NO_SLOT   = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic advance;
        logic do_bump;
        logic do_open;
        logic do_clear;
        logic do_null;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic in_release;
        logic in_zero;
        logic hit;
        logic miss;
        logic out_busy;
    } dp_status_t;

endpackage

### sv/first_fit_chunk_bump_allocator.sv
// ----------------------------------------------------------------------------
// First-fit chunk bump allocator
// Handles one transaction at a time: release all and zero size go straight to
// the result, while an allocation first runs a first-fit scan that reads one
// chunk slot per cycle from the slot RAM, then bumps the hit chunk or opens a
// new one. The result waits while the previous one is still unaccepted.
// Reset clears all chunks and totals and loads chunk_size with 16 MiB; the slot
// RAM itself is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module first_fit_chunk_bump_allocator #(
    parameter int MAX_CHUNKS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [ffcba_pkg::SIZE_W-1:0]      s_alloc_size,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [ffcba_pkg::INDEX_W-1:0]     m_chunk_index,
    output logic [ffcba_pkg::SIZE_W-1:0]      m_byte_offset,
    output logic [ffcba_pkg::TOTAL_W-1:0]     m_reserved_total,
    output logic [ffcba_pkg::TOTAL_W-1:0]     m_unused_total,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffcba_pkg::SIZE_W-1:0]      cfg_data
);

    import ffcba_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    ffcba_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (dp_status),
        .cmd    (dp_cmd)
    );

    ffcba_dp #(
        .MAX_CHUNKS(MAX_CHUNKS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_cmd           (s_cmd),
        .s_alloc_size    (s_alloc_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_chunk_index   (m_chunk_index),
        .m_byte_offset   (m_byte_offset),
        .m_reserved_total(m_reserved_total),
        .m_unused_total  (m_unused_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .cmd             (dp_cmd),
        .status          (dp_status)
    );

endmodule

### sv/ffcba_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffcba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/ffcba_ctrl.sv
// ----------------------------------------------------------------------------
// First-fit chunk bump allocator controller
// Sequences accept, slot scan, slot update or release/null handling, and result hand-off.
// ----------------------------------------------------------------------------
module ffcba_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ffcba_pkg::dp_status_t status,
    output ffcba_pkg::dp_cmd_t    cmd
);

    import ffcba_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_BUMP  = 7'b0000100,
        S_OPEN  = 7'b0001000,
        S_CLEAR = 7'b0010000,
        S_NULL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    priority if (status.in_release) begin
                        state_next = S_CLEAR;
                    end else if (status.in_zero) begin
                        state_next = S_NULL;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                priority if (status.hit) begin
                    state_next = S_BUMP;
                end else if (status.miss) begin
                    state_next = S_OPEN;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            S_BUMP: begin
                cmd.do_bump = 1'b1;
                state_next  = S_DONE;
            end
            S_OPEN: begin
                cmd.do_open = 1'b1;
                state_next  = S_DONE;
            end
            S_CLEAR: begin
                cmd.do_clear = 1'b1;
                state_next   = S_DONE;
            end
            S_NULL: begin
                cmd.do_null = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/ffcba_dp.sv
// ----------------------------------------------------------------------------
// First-fit chunk bump allocator datapath
// Slot RAM, full flags, scan counters, running totals and result register.
// ----------------------------------------------------------------------------
`include "first_fit_chunk_bump_allocator_macros.svh"

module ffcba_dp #(
    parameter int MAX_CHUNKS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_cmd,
    input  logic [ffcba_pkg::SIZE_W-1:0]      s_alloc_size,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [ffcba_pkg::INDEX_W-1:0]     m_chunk_index,
    output logic [ffcba_pkg::SIZE_W-1:0]      m_byte_offset,
    output logic [ffcba_pkg::TOTAL_W-1:0]     m_reserved_total,
    output logic [ffcba_pkg::TOTAL_W-1:0]     m_unused_total,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffcba_pkg::SIZE_W-1:0]      cfg_data,
    input  ffcba_pkg::dp_cmd_t                cmd,
    output ffcba_pkg::dp_status_t             status
);

    import ffcba_pkg::*;

    localparam int ADDR_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int IDXX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int SLOT_W = 2 * SIZE_W;

    logic [SIZE_W-1:0]     chunk_size_reg;
    logic [SIZE_W-1:0]     in_size_reg;
    logic [MAX_CHUNKS-1:0] full_reg;
    logic [CNT_W-1:0]      open_count_reg;
    logic [TOTAL_W-1:0]    reserved_reg;
    logic [TOTAL_W-1:0]    unused_reg;
    logic [CNT_W-1:0]      rd_idx_reg;
    logic [CNT_W-1:0]      chk_idx_reg;
    logic                  chk_started_reg;
    logic [SIZE_W-1:0]     hit_cap_reg;
    logic [SIZE_W-1:0]     hit_fill_reg;
    status_t               res_status_reg;
    logic [CNT_W-1:0]      res_idx_reg;
    logic [SIZE_W-1:0]     res_off_reg;
    logic                  m_valid_reg;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [SLOT_W-1:0]     ram_wdata;
    logic [SLOT_W-1:0]     ram_rdata;
    logic [SIZE_W-1:0]     rd_cap;
    logic [SIZE_W-1:0]     rd_fill;
    logic [SIZE_W-1:0]     rd_avail;
    logic                  chk_in_range;
    logic                  hit;
    logic [SIZE_W-1:0]     bump_fill;
    logic                  too_large;
    logic                  no_slot;
    logic                  open_ok;
    logic [IDXX_W-1:0]     res_idx_ext;

    assign cfg_ready = 1'b1;

    assign rd_cap       = ram_rdata[SLOT_W-1:SIZE_W];
    assign rd_fill      = ram_rdata[SIZE_W-1:0];
    assign rd_avail     = rd_cap - rd_fill;
    assign chk_in_range = chk_idx_reg < open_count_reg;
    assign hit          = cmd.scan && chk_started_reg && chk_in_range
                          && !full_reg[chk_idx_reg[ADDR_W-1:0]]
                          && (in_size_reg <= rd_avail);

    assign bump_fill = hit_fill_reg + in_size_reg;
    assign too_large = in_size_reg > chunk_size_reg;
    assign no_slot   = open_count_reg >= CNT_W'(MAX_CHUNKS);
    assign open_ok   = !too_large && !no_slot;

    assign ram_we    = cmd.do_bump || (cmd.do_open && open_ok);
    assign ram_waddr = cmd.do_bump ? chk_idx_reg[ADDR_W-1:0] : open_count_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.do_bump ? {hit_cap_reg, bump_fill} : {chunk_size_reg, in_size_reg};

    assign status.in_release = (s_cmd == CMD_RELEASE);
    assign status.in_zero    = (s_alloc_size == '0);
    assign status.hit        = hit;
    assign status.miss       = chk_started_reg && !chk_in_range;
    assign status.out_busy   = m_valid_reg && !m_ready;

    ffcba_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_CHUNKS)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_idx_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= CHUNK_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            chunk_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_size_reg <= s_alloc_size;
        end
        if (hit) begin
            hit_cap_reg  <= rd_cap;
            hit_fill_reg <= rd_fill;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg      <= '0;
            chk_idx_reg     <= '0;
            chk_started_reg <= 1'b0;
        end else if (cmd.accept) begin
            rd_idx_reg      <= '0;
            chk_idx_reg     <= '0;
            chk_started_reg <= 1'b0;
        end else if (cmd.advance) begin
            rd_idx_reg      <= rd_idx_reg + 1'b1;
            chk_idx_reg     <= rd_idx_reg;
            chk_started_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg       <= '0;
            open_count_reg <= '0;
            reserved_reg   <= '0;
            unused_reg     <= '0;
        end else if (cmd.do_clear) begin
            full_reg       <= '0;
            open_count_reg <= '0;
            reserved_reg   <= '0;
            unused_reg     <= '0;
        end else if (cmd.do_bump) begin
            full_reg[chk_idx_reg[ADDR_W-1:0]] <= (bump_fill == hit_cap_reg);
            unused_reg <= unused_reg - TOTAL_W'(in_size_reg);
        end else if (cmd.do_open && open_ok) begin
            full_reg[open_count_reg[ADDR_W-1:0]] <= (in_size_reg == chunk_size_reg);
            open_count_reg <= open_count_reg + 1'b1;
            reserved_reg   <= reserved_reg + TOTAL_W'(chunk_size_reg);
            unused_reg     <= unused_reg + TOTAL_W'(chunk_size_reg - in_size_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_bump) begin
            res_status_reg <= STATUS_OK;
            res_idx_reg    <= chk_idx_reg;
            res_off_reg    <= hit_fill_reg;
        end else if (cmd.do_open) begin
            res_idx_reg <= '0;
            res_off_reg <= '0;
            priority if (too_large) begin
                res_status_reg <= STATUS_TOO_LARGE;
            end else if (no_slot) begin
                res_status_reg <= STATUS_NO_SLOT;
            end else begin
                res_status_reg <= STATUS_OK;
                res_idx_reg    <= open_count_reg;
            end
        end else if (cmd.do_clear) begin
            res_status_reg <= STATUS_OK;
            res_idx_reg    <= '0;
            res_off_reg    <= '0;
        end else if (cmd.do_null) begin
            res_status_reg <= STATUS_NULL;
            res_idx_reg    <= '0;
            res_off_reg    <= '0;
        end
    end

    assign res_idx_ext = IDXX_W'(res_idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status         <= res_status_reg;
            m_chunk_index    <= res_idx_ext[INDEX_W-1:0];
            m_byte_offset    <= res_off_reg;
            m_reserved_total <= reserved_reg;
            m_unused_total   <= unused_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    `FFCBA_ASSERT_SAME(a_open_bound, aclk, aresetn, 1'b1, open_count_reg <= CNT_W'(MAX_CHUNKS), "open chunk count exceeds slot count")
    `FFCBA_ASSERT_SAME(a_hit_open, aclk, aresetn, hit, chk_idx_reg < open_count_reg, "scan hit on a slot that is not open")
    `FFCBA_ASSERT_NEXT(a_clear_empty, aclk, aresetn, cmd.do_clear, (open_count_reg == '0) && (reserved_reg == '0) && (unused_reg == '0) && (full_reg == '0), "release all left chunk state behind")
    `FFCBA_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.load_out, !(m_valid_reg && !m_ready), "result register overwritten before its transaction")

endmodule

### sim/tb_first_fit_chunk_bump_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit chunk bump allocator testbench
// Drives allocate and release-all requests through valid/ready handshakes.
// An arena tracker keeps its own copy of every chunk slot and checks each
// returned grant field by field. The run steps through several chunk sizes
// and idle patterns, and ends after a directed opening and random traffic.
// ----------------------------------------------------------------------------
module tb_first_fit_chunk_bump_allocator;
    import ffcba_pkg::*;

    localparam int SLOT_COUNT      = 16;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 3;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 500000;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   chunk_index;
        logic [SIZE_W-1:0]    byte_offset;
        logic [TOTAL_W-1:0]   reserved_total;
        logic [TOTAL_W-1:0]   unused_total;
    } grant_t;

    class arena_tracker;
        logic [SIZE_W-1:0]  chunk_size;
        logic [SIZE_W-1:0]  capacity [SLOT_COUNT];
        logic [SIZE_W-1:0]  fill [SLOT_COUNT];
        bit                 full [SLOT_COUNT];
        int                 open_count;
        logic [36:0]        reserved_sum;
        logic [36:0]        unused_sum;
        grant_t             owed_grants [$];
        int                 mismatches;

        function new();
            chunk_size   = CHUNK_SIZE_RESET;
            open_count   = 0;
            reserved_sum = '0;
            unused_sum   = '0;
            mismatches   = 0;
            foreach (full[i]) begin
                full[i] = 1'b0;
            end
        endfunction

        function int pending();
            return owed_grants.size();
        endfunction

        function logic [SIZE_W-1:0] room_in(int slot);
            if (slot < open_count && !full[slot]) begin
                return capacity[slot] - fill[slot];
            end
            return '0;
        endfunction

        function void set_chunk_size(logic [SIZE_W-1:0] value);
            chunk_size = value;
        endfunction

        function void note_request(logic cmd, logic [SIZE_W-1:0] size);
            grant_t             g;
            logic [SIZE_W-1:0]  avail;
            bit                 placed;
            int                 i;
            g        = '0;
            g.status = STATUS_OK;
            placed   = 1'b0;
            if (cmd == CMD_RELEASE) begin
                foreach (full[k]) begin
                    full[k] = 1'b0;
                end
                open_count   = 0;
                reserved_sum = '0;
                unused_sum   = '0;
            end else if (size == '0) begin
                g.status = STATUS_NULL;
            end else begin
                for (i = 0; i < open_count && !placed; i++) begin
                    if (!full[i]) begin
                        avail = capacity[i] - fill[i];
                        if (size <= avail) begin
                            g.chunk_index = i[INDEX_W-1:0];
                            g.byte_offset = fill[i];
                            fill[i]       = fill[i] + size;
                            full[i]       = (fill[i] == capacity[i]);
                            unused_sum    = unused_sum - {5'b0, size};
                            placed        = 1'b1;
                        end
                    end
                end
                if (!placed) begin
                    if (size > chunk_size) begin
                        g.status = STATUS_TOO_LARGE;
                    end else if (open_count >= SLOT_COUNT) begin
                        g.status = STATUS_NO_SLOT;
                    end else begin
                        avail                = chunk_size - size;
                        capacity[open_count] = chunk_size;
                        fill[open_count]     = size;
                        full[open_count]     = (size == chunk_size);
                        g.chunk_index        = open_count[INDEX_W-1:0];
                        open_count++;
                        reserved_sum         = reserved_sum + {5'b0, chunk_size};
                        unused_sum           = unused_sum + {5'b0, avail};
                    end
                end
            end
            g.reserved_total = reserved_sum[TOTAL_W-1:0];
            g.unused_total   = unused_sum[TOTAL_W-1:0];
            owed_grants = {owed_grants, g};
        endfunction

        task report_mismatch(string what, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
            mismatches++;
            $display("mismatch in %s at %0t ns: got 0x%0h, want 0x%0h", what, $time, got, want);
        endtask

        task check_grant(grant_t got);
            grant_t want;
            if (owed_grants.size() == 0) begin
                report_mismatch("unrequested result", got.status, '0);
                return;
            end
            want = owed_grants.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.chunk_index !== want.chunk_index)
                report_mismatch("chunk_index", got.chunk_index, want.chunk_index);
            if (got.byte_offset !== want.byte_offset)
                report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
            if (got.reserved_total !== want.reserved_total)
                report_mismatch("reserved_total", got.reserved_total, want.reserved_total);
            if (got.unused_total !== want.unused_total)
                report_mismatch("unused_total", got.unused_total, want.unused_total);
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_cmd;
    logic [SIZE_W-1:0]    s_alloc_size;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_status;
    logic [INDEX_W-1:0]   m_chunk_index;
    logic [SIZE_W-1:0]    m_byte_offset;
    logic [TOTAL_W-1:0]   m_reserved_total;
    logic [TOTAL_W-1:0]   m_unused_total;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data;

    arena_tracker arena;
    int           src_idle_pct;
    int           sink_idle_pct;
    int           cycle_count;

    first_fit_chunk_bump_allocator #(
        .MAX_CHUNKS(SLOT_COUNT)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_alloc_size    (s_alloc_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_chunk_index   (m_chunk_index),
        .m_byte_offset   (m_byte_offset),
        .m_reserved_total(m_reserved_total),
        .m_unused_total  (m_unused_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            arena.check_grant('{status_t'(m_status), m_chunk_index, m_byte_offset,
                                m_reserved_total, m_unused_total});
        end
    end

    task automatic send_item(input logic cmd, input logic [SIZE_W-1:0] size);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_alloc_size <= size;
        do @(posedge aclk); while (!(s_valid && s_ready));
        arena.note_request(cmd, size);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (arena.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_chunk_size(input logic [SIZE_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        arena.set_chunk_size(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned        roll;
        int                 slot;
        logic [SIZE_W-1:0]  cs;
        logic [SIZE_W-1:0]  room;
        cs   = arena.chunk_size;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 20 && arena.open_count > 0) begin
            slot = $urandom_range(arena.open_count - 1);
            room = arena.room_in(slot);
            if (room != '0)
                return room;
        end
        if (roll < 28 && cs != SIZE_MAX)
            return $urandom_range(SIZE_MAX, cs + 1);
        if (roll < 36)
            return $urandom();
        if (roll < 68)
            return $urandom_range(cs, 1);
        return $urandom_range((cs >> 3) + 1, 1);
    endfunction

    function automatic logic [SIZE_W-1:0] phase_chunk_size(int phase);
        case (phase)
            0: return 32'd37;
            1: return 32'd1;
            2: return SIZE_MAX;
            3: return $urandom_range(5000, 2);
            4: return $urandom_range(SIZE_MAX, 1);
            default: return 32'd4096;
        endcase
    endfunction

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = CMD_ALLOC;
        s_alloc_size  = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        cycle_count   = 0;
        src_idle_pct  = 17;
        sink_idle_pct = 59;
        arena         = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Opening traffic runs at the reset chunk size of 16 MiB.
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, 32'd1);
        send_item(CMD_ALLOC, CHUNK_SIZE_RESET - 1);
        send_item(CMD_ALLOC, SIZE_MAX);
        send_item(CMD_ALLOC, CHUNK_SIZE_RESET);
        send_item(CMD_RELEASE, $urandom());

        // A chunk opened under a large setting still serves requests that
        // exceed a later, smaller chunk size.
        write_chunk_size(SIZE_MAX);
        send_item(CMD_ALLOC, 32'd100);
        write_chunk_size(32'd1);
        send_item(CMD_ALLOC, 32'd5000);
        send_item(CMD_RELEASE, SIZE_MAX);

        // Fill every slot with a maximal chunk, then run out of slots.
        write_chunk_size(SIZE_MAX);
        repeat (SLOT_COUNT) send_item(CMD_ALLOC, SIZE_MAX);
        send_item(CMD_ALLOC, SIZE_MAX);
        send_item(CMD_ALLOC, 32'd1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    src_idle_pct  = 17;
                    sink_idle_pct = 59;
                end
                1: begin
                    src_idle_pct  = 59;
                    sink_idle_pct = 17;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            write_chunk_size(phase_chunk_size(phase));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(199) == 0)
                    drain_results();
                if ($urandom_range(99) < 3)
                    send_item(CMD_RELEASE, $urandom());
                else
                    send_item(CMD_ALLOC, pick_size());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (arena.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/ffcba_pkg.sv
sv/ffcba_ram.sv
sv/ffcba_ctrl.sv
sv/ffcba_dp.sv
sv/first_fit_chunk_bump_allocator.sv
sim/tb_first_fit_chunk_bump_allocator.sv
